FILE: design/abpw_pkg.sv
package abpw_pkg;

  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 240;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COORD_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_BG   = 1'b1;

  localparam logic [1:0] MODE_PLAIN      = 2'd0;
  localparam logic [1:0] MODE_BG_MIX     = 2'd1;
  localparam logic [1:0] MODE_STORED_MIX = 2'd2;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  typedef enum logic [1:0] {
    ST_WRITTEN     = 2'd0,
    ST_TRANSPARENT = 2'd1,
    ST_OUTSIDE     = 2'd2,
    ST_READ        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MIX,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PIX_W-1:0] bg;
  } cfg_t;

endpackage

FILE: design/abpw_ram.sv
module abpw_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 76800,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/abpw_regs.sv
module abpw_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abpw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [abpw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [abpw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output abpw_pkg::cfg_t                      cfg
);

  import abpw_pkg::*;

  logic [1:0]       mode_r;
  logic [PIX_W-1:0] bg_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STORED_MIX;
      bg_r   <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE: mode_r <= pwdata[1:0];
        REG_BG:   bg_r   <= pwdata[PIX_W-1:0];
        default:  mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {{(CFG_DATA_W-2){1'b0}}, mode_r};
      REG_BG:   prdata = {{(CFG_DATA_W-PIX_W){1'b0}}, bg_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.mode = mode_r;
  assign cfg.bg   = bg_r;

endmodule

FILE: design/abpw_blend.sv
module abpw_blend (
  input  logic                       clk,
  input  logic                       en,
  input  logic [abpw_pkg::PIX_W-1:0] fresh,
  input  logic [abpw_pkg::PIX_W-1:0] other,
  input  logic [abpw_pkg::CH_W-1:0]  alpha,
  output logic [abpw_pkg::PIX_W-1:0] mixed
);

  import abpw_pkg::*;

  logic [CH_W-1:0]   inv_alpha;
  logic [2*CH_W-1:0] prod_new_r [3];
  logic [2*CH_W-1:0] prod_old_r [3];
  logic [2*CH_W-1:0] sum        [3];

  assign inv_alpha = ALPHA_OPAQUE - alpha;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    always_ff @(posedge clk) begin
      if (en) begin
        prod_new_r[c] <= fresh[c*CH_W +: CH_W] * alpha;
        prod_old_r[c] <= other[c*CH_W +: CH_W] * inv_alpha;
      end
    end
    assign sum[c] = prod_new_r[c] + prod_old_r[c];
    assign mixed[c*CH_W +: CH_W] = sum[c][2*CH_W-1:CH_W];
  end

endmodule

FILE: design/alpha_blend_pixel_writer_top.sv
// Pixel engine over a FRAME_WIDTH x FRAME_HEIGHT frame of RGB888 pixels held
// in one single-port-per-direction synchronous memory. Each item keeps busy
// high from its accepting edge until its result is out; address computation,
// memory read, channel multiply and write-back run in turn in the states
// S_ADDR, S_READ, S_MIX and S_FIN. The result is shown for exactly one cycle
// on out_valid, in the cycle after write-back, and the receiver cannot stall
// it. A new item may be started in that same cycle; none is accepted while
// busy is high, so an item is never taken before the last one is through.
// Writes outside the frame or with alpha zero leave the frame untouched and
// report zero color. Reads of pixels never written return undefined data.
module alpha_blend_pixel_writer_top #(
  parameter int FRAME_WIDTH  = abpw_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = abpw_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [abpw_pkg::COORD_W-1:0]        in_pos_x,
  input  logic [abpw_pkg::COORD_W-1:0]        in_pos_y,
  input  logic [abpw_pkg::CH_W-1:0]           in_red,
  input  logic [abpw_pkg::CH_W-1:0]           in_green,
  input  logic [abpw_pkg::CH_W-1:0]           in_blue,
  input  logic [abpw_pkg::CH_W-1:0]           in_alpha,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [abpw_pkg::CH_W-1:0]           out_red,
  output logic [abpw_pkg::CH_W-1:0]           out_green,
  output logic [abpw_pkg::CH_W-1:0]           out_blue,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abpw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [abpw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [abpw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import abpw_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam logic [COORD_W-1:0] FW_C = COORD_W'(FRAME_WIDTH);
  localparam logic [COORD_W-1:0] FH_C = COORD_W'(FRAME_HEIGHT);
  localparam logic [XW-1:0] X_LAST = XW'(FRAME_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(FRAME_HEIGHT - 1);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  cfg_t             cfg;
  logic             cmd_r;
  logic [XW-1:0]    x_r;
  logic [YW-1:0]    y_r;
  logic [PIX_W-1:0] rgb_r;
  logic [CH_W-1:0]  alpha_r;
  logic             outside_r;
  logic [AW-1:0]    addr_r;

  logic             x_neg, y_neg, x_big, y_big;
  logic [XW-1:0]    x_clamp;
  logic [YW-1:0]    y_clamp;

  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] other;
  logic [PIX_W-1:0] mixed;
  logic [PIX_W-1:0] stored_rgb;
  logic             do_mix;
  logic             write_ok;
  status_t          status_nxt;
  logic [PIX_W-1:0] res_rgb_nxt;
  logic [1:0]       status_r;
  logic [PIX_W-1:0] res_rgb_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign x_neg = in_pos_x[COORD_W-1];
  assign y_neg = in_pos_y[COORD_W-1];
  assign x_big = !x_neg && (in_pos_x >= FW_C);
  assign y_big = !y_neg && (in_pos_y >= FH_C);
  assign x_clamp = x_neg ? '0 : (x_big ? X_LAST : in_pos_x[XW-1:0]);
  assign y_clamp = y_neg ? '0 : (y_big ? Y_LAST : in_pos_y[YW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: state_nxt = S_READ;
      S_READ: state_nxt = S_MIX;
      S_MIX:  state_nxt = S_FIN;
      S_FIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      x_r       <= x_clamp;
      y_r       <= y_clamp;
      rgb_r     <= {in_red, in_green, in_blue};
      alpha_r   <= in_alpha;
      outside_r <= x_neg || y_neg || x_big || y_big;
    end
    if (state_r == S_ADDR) begin
      addr_r <= AW'(AW'(y_r) * AW'(FRAME_WIDTH)) + AW'(x_r);
    end
    if (state_r == S_FIN) begin
      status_r  <= status_nxt;
      res_rgb_r <= res_rgb_nxt;
    end
  end

  abpw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign other = cfg.mode[1] ? rdata : cfg.bg;

  abpw_blend u_blend (
    .clk   (clk),
    .en    (state_r == S_MIX),
    .fresh (rgb_r),
    .other (other),
    .alpha (alpha_r),
    .mixed (mixed)
  );

  assign do_mix     = (alpha_r != ALPHA_OPAQUE) && (cfg.mode != MODE_PLAIN);
  assign stored_rgb = do_mix ? mixed : rgb_r;
  assign write_ok   = (cmd_r == CMD_WRITE) && !outside_r && (alpha_r != ALPHA_CLEAR);

  always_comb begin
    if (cmd_r == CMD_READ) begin
      status_nxt  = ST_READ;
      res_rgb_nxt = rdata;
    end else if (outside_r) begin
      status_nxt  = ST_OUTSIDE;
      res_rgb_nxt = '0;
    end else if (alpha_r == ALPHA_CLEAR) begin
      status_nxt  = ST_TRANSPARENT;
      res_rgb_nxt = '0;
    end else begin
      status_nxt  = ST_WRITTEN;
      res_rgb_nxt = stored_rgb;
    end
  end

  abpw_ram #(
    .WIDTH  (PIX_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_frame (
    .clk   (clk),
    .we    ((state_r == S_FIN) && write_ok),
    .waddr (addr_r),
    .wdata (stored_rgb),
    .re    (state_r == S_READ),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_red    = res_rgb_r[3*CH_W-1:2*CH_W];
  assign out_green  = res_rgb_r[2*CH_W-1:CH_W];
  assign out_blue   = res_rgb_r[CH_W-1:0];

endmodule

FILE: sim/tb_alpha_blend_pixel_writer_top.sv
`timescale 1ns / 1ps

module tb_alpha_blend_pixel_writer_top;
  import abpw_pkg::*;

  localparam int W = FRAME_WIDTH_DEF;
  localparam int H = FRAME_HEIGHT_DEF;
  localparam int FRAME_PIXELS = W * H;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES = 7;
  localparam int NUM_DIRECTED = 19;

  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] BG_ADDR = {REG_BG, 2'b00};

  typedef struct packed {
    logic cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
  } pixel_cmd_t;

  typedef struct packed {
    status_t status;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_result_t;

  typedef struct packed {
    pixel_cmd_t cmd;
    logic known;
    pixel_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [COORD_W-1:0] in_pos_x;
  logic [COORD_W-1:0] in_pos_y;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;
  logic out_valid;
  logic [1:0] out_status;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  alpha_blend_pixel_writer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_alpha(in_alpha),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  logic [PIX_W-1:0] frame_mem [FRAME_PIXELS];
  bit written_map [FRAME_PIXELS];
  int written_list [$];
  pixel_result_t pending_pixels [$];
  logic [1:0] cur_mode;
  logic [PIX_W-1:0] cur_bg;
  int fail_count = 0;
  int gap_pct = 15;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{CMD_WRITE, 16'h0000, 16'h0000, 8'hFF, 8'h00, 8'h80, 8'hFF}, 1'b1,
      '{ST_WRITTEN, 8'hFF, 8'h00, 8'h80}},
    '{'{CMD_WRITE, 16'd319, 16'd239, 8'h12, 8'h34, 8'h56, 8'hFF}, 1'b1,
      '{ST_WRITTEN, 8'h12, 8'h34, 8'h56}},
    '{'{CMD_WRITE, 16'd319, 16'h0000, 8'h01, 8'h02, 8'h03, 8'hFF}, 1'b1,
      '{ST_WRITTEN, 8'h01, 8'h02, 8'h03}},
    '{'{CMD_WRITE, 16'h0000, 16'd239, 8'hFE, 8'hFD, 8'hFC, 8'hFF}, 1'b1,
      '{ST_WRITTEN, 8'hFE, 8'hFD, 8'hFC}},
    '{'{CMD_READ, 16'h8000, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{ST_READ, 8'hFF, 8'h00, 8'h80}},
    '{'{CMD_READ, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{ST_READ, 8'h12, 8'h34, 8'h56}},
    '{'{CMD_READ, 16'd320, 16'hFFFF, 8'hAA, 8'h55, 8'hAA, 8'h00}, 1'b1,
      '{ST_READ, 8'h01, 8'h02, 8'h03}},
    '{'{CMD_READ, 16'hFFFF, 16'd240, 8'hFF, 8'hFF, 8'hFF, 8'h80}, 1'b1,
      '{ST_READ, 8'hFE, 8'hFD, 8'hFC}},
    '{'{CMD_WRITE, 16'd320, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{ST_OUTSIDE, 8'h00, 8'h00, 8'h00}},
    '{'{CMD_WRITE, 16'hFFFF, 16'd5, 8'h11, 8'h22, 8'h33, 8'h00}, 1'b1,
      '{ST_OUTSIDE, 8'h00, 8'h00, 8'h00}},
    '{'{CMD_WRITE, 16'h0000, 16'd240, 8'h11, 8'h22, 8'h33, 8'h40}, 1'b1,
      '{ST_OUTSIDE, 8'h00, 8'h00, 8'h00}},
    '{'{CMD_WRITE, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 8'hC8}, 1'b1,
      '{ST_OUTSIDE, 8'h00, 8'h00, 8'h00}},
    '{'{CMD_WRITE, 16'd5, 16'd5, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1,
      '{ST_TRANSPARENT, 8'h00, 8'h00, 8'h00}},
    '{'{CMD_WRITE, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0, '0},
    '{'{CMD_WRITE, 16'h0000, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'h01}, 1'b0, '0},
    '{'{CMD_WRITE, 16'h0000, 16'h0000, 8'h00, 8'hFF, 8'h7F, 8'hFE}, 1'b0, '0},
    '{'{CMD_READ, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
    '{'{CMD_WRITE, 16'd160, 16'd120, 8'h80, 8'h80, 8'h80, 8'hFF}, 1'b1,
      '{ST_WRITTEN, 8'h80, 8'h80, 8'h80}},
    '{'{CMD_READ, 16'd160, 16'd120, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{ST_READ, 8'h80, 8'h80, 8'h80}}
  };

  logic [1:0] phase_mode [NUM_PHASES] = '{MODE_PLAIN, MODE_BG_MIX, MODE_BG_MIX, MODE_BG_MIX,
                                           MODE_STORED_MIX, MODE_UNUSED, MODE_STORED_MIX};
  logic [PIX_W-1:0] phase_bg [NUM_PHASES] = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h80FF01,
                                              24'h000000, 24'h000000, 24'h000000};
  bit phase_random_bg [NUM_PHASES] = '{0, 0, 0, 0, 1, 1, 0};
  bit phase_gapless [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0};

  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] fresh,
                                                  logic [CH_W-1:0] other,
                                                  logic [CH_W-1:0] a);
    int sum;
    sum = int'(fresh) * int'(a) + int'(other) * (int'(ALPHA_OPAQUE) - int'(a));
    return CH_W'(sum >> CH_W);
  endfunction

  // Works out the result of one item and updates the frame copy.
  function automatic pixel_result_t blend_pixel(pixel_cmd_t c);
    int x;
    int y;
    int addr;
    logic [PIX_W-1:0] other;
    logic [PIX_W-1:0] rgb;
    pixel_result_t res;
    x = int'($signed(c.x));
    y = int'($signed(c.y));
    res = '0;
    if (c.cmd == CMD_READ) begin
      x = (x < 0) ? 0 : ((x >= W) ? W - 1 : x);
      y = (y < 0) ? 0 : ((y >= H) ? H - 1 : y);
      res.status = ST_READ;
      {res.r, res.g, res.b} = frame_mem[y * W + x];
    end else if (x < 0 || y < 0 || x >= W || y >= H) begin
      res.status = ST_OUTSIDE;
    end else if (c.a == ALPHA_CLEAR) begin
      res.status = ST_TRANSPARENT;
    end else begin
      addr = y * W + x;
      rgb = {c.r, c.g, c.b};
      if (c.a != ALPHA_OPAQUE && cur_mode != MODE_PLAIN) begin
        other = cur_mode[1] ? frame_mem[addr] : cur_bg;
        rgb = {mix_channel(c.r, other[23:16], c.a), mix_channel(c.g, other[15:8], c.a),
               mix_channel(c.b, other[7:0], c.a)};
      end
      frame_mem[addr] = rgb;
      if (!written_map[addr]) begin
        written_map[addr] = 1'b1;
        written_list.push_back(addr);
      end
      res.status = ST_WRITTEN;
      {res.r, res.g, res.b} = rgb;
    end
    return res;
  endfunction

  function automatic int outside_coord(int size);
    return ($urandom_range(1) == 0) ? -int'($urandom_range(32768, 1)) :
                                      int'($urandom_range(32767, size));
  endfunction

  // Reads only touch written pixels; edge pixels are often reached through
  // coordinates beyond the frame. Writes mostly go to the edges and to a
  // small hot block so that blending stacks on earlier values.
  function automatic pixel_cmd_t random_item();
    pixel_cmd_t c;
    int kind;
    int x;
    int y;
    int addr;
    int pick;
    c.cmd = CMD_WRITE;
    c.r = CH_W'($urandom);
    c.g = CH_W'($urandom);
    c.b = CH_W'($urandom);
    c.a = CH_W'($urandom);
    kind = $urandom_range(99);
    if (kind < 40) begin
      c.cmd = CMD_READ;
      addr = written_list[$urandom_range(written_list.size() - 1)];
      x = addr % W;
      y = addr / W;
      if (x == 0 && $urandom_range(1) == 1) x = -int'($urandom_range(32768, 1));
      if (x == W - 1 && $urandom_range(1) == 1) x = $urandom_range(32767, W);
      if (y == 0 && $urandom_range(1) == 1) y = -int'($urandom_range(32768, 1));
      if (y == H - 1 && $urandom_range(1) == 1) y = $urandom_range(32767, H);
    end else if (kind < 52) begin
      if ($urandom_range(1) == 0) begin
        x = outside_coord(W);
        y = int'($signed(COORD_W'($urandom)));
      end else begin
        x = int'($signed(COORD_W'($urandom)));
        y = outside_coord(H);
      end
      if ($urandom_range(3) == 0) c.a = ALPHA_CLEAR;
    end else begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        x = $urandom_range(1) ? $urandom_range(3) : W - 1 - $urandom_range(3);
        y = $urandom_range(1) ? $urandom_range(3) : H - 1 - $urandom_range(3);
      end else if (pick < 8) begin
        x = 100 + $urandom_range(7);
        y = 50 + $urandom_range(3);
      end else begin
        x = $urandom_range(W - 1);
        y = $urandom_range(H - 1);
      end
      pick = $urandom_range(99);
      if (pick < 8) c.a = ALPHA_CLEAR;
      else if (pick < 30) c.a = ALPHA_OPAQUE;
      else c.a = CH_W'($urandom_range(254, 1));
      if (cur_mode[1] && c.a != ALPHA_OPAQUE && c.a != ALPHA_CLEAR
          && !written_map[y * W + x]) begin
        c.a = ALPHA_OPAQUE;
      end
    end
    c.x = COORD_W'(x);
    c.y = COORD_W'(y);
    return c;
  endfunction

  task automatic send_item(input pixel_cmd_t c, input logic known, input pixel_result_t res);
    pixel_result_t predicted;
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      while (busy) @(negedge clk);
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
    start = 1'b1;
    in_command = c.cmd;
    in_pos_x = c.x;
    in_pos_y = c.y;
    in_red = c.r;
    in_green = c.g;
    in_blue = c.b;
    in_alpha = c.a;
    do @(posedge clk); while (busy);
    predicted = blend_pixel(c);
    pending_pixels.push_back(known ? res : predicted);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] expected);
    logic [CFG_DATA_W-1:0] value;
    apb_access(1'b0, addr, '0, value);
    if (value !== expected) begin
      $display("%0t: register at %0d read back, expected %08h, got %08h",
               $time, addr, expected, value);
      fail_count++;
    end
  endtask

  task automatic set_blend(input logic [1:0] mode, input logic [PIX_W-1:0] bg);
    logic [CFG_DATA_W-1:0] unused;
    apb_access(1'b1, MODE_ADDR, CFG_DATA_W'(mode), unused);
    apb_access(1'b1, BG_ADDR, CFG_DATA_W'(bg), unused);
    cur_mode = mode;
    cur_bg = bg;
    check_register(MODE_ADDR, CFG_DATA_W'(mode));
    check_register(BG_ADDR, CFG_DATA_W'(bg));
  endtask

  always @(posedge clk) begin
    pixel_result_t seen;
    pixel_result_t want;
    if (rst_n && out_valid) begin
      seen = {status_t'(out_status), out_red, out_green, out_blue};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, got status %0d rgb %02h%02h%02h",
                 $time, seen.status, seen.r, seen.g, seen.b);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        status_seen[seen.status]++;
        if (seen.status !== want.status || seen.r !== want.r || seen.g !== want.g
            || seen.b !== want.b) begin
          $display({"%0t: result mismatch, expected status %0d rgb %02h%02h%02h,",
                    " got status %0d rgb %02h%02h%02h"},
                   $time, want.status, want.r, want.g, want.b,
                   seen.status, seen.r, seen.g, seen.b);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out with %0d results still expected.", pending_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_WRITE;
    in_pos_x = '0;
    in_pos_y = '0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_alpha = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_mode = MODE_STORED_MIX;
    cur_bg = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_register(MODE_ADDR, CFG_DATA_W'(MODE_STORED_MIX));
    check_register(BG_ADDR, '0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].res);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_blend(phase_mode[p], phase_random_bg[p] ? PIX_W'($urandom) : phase_bg[p]);
      gap_pct = phase_gapless[p] ? 0 : 15;
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      drain();
    end

    $display("Checked %0d writes, %0d transparent drops, %0d outside drops and %0d reads.",
             status_seen[ST_WRITTEN], status_seen[ST_TRANSPARENT],
             status_seen[ST_OUTSIDE], status_seen[ST_READ]);
    $display("All four blend modes ran with dark, bright and random background colors.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/abpw_pkg.sv
design/abpw_ram.sv
design/abpw_regs.sv
design/abpw_blend.sv
design/alpha_blend_pixel_writer_top.sv
sim/tb_alpha_blend_pixel_writer_top.sv
